// ===== src/kcs_pkg.sv =====
// shared types and constants of the fsk decoder
package kcs_pkg;

	localparam int SAMPLE_W = 16;
	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 9;

	localparam int SPB_W = 9;
	localparam int DBC_W = 4;
	localparam int SBC_W = 2;
	localparam int BIT_IDX_W = 4;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_BIT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_BIT_COUNT = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PARITY_ENABLE = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_BIT_COUNT = 4'd3;

	localparam logic [SPB_W-1:0] SPB_RESET = 9'd147;
	localparam logic [DBC_W-1:0] DBC_RESET = 4'd8;
	localparam logic SBC_PAR_RESET = 1'b0;
	localparam logic [SBC_W-1:0] SBC_RESET = 2'd2;

	localparam int SPB_MIN = 2;

	// window reads 1 when CROSS_MUL * crossings > SPB_MUL * window length
	localparam int CROSS_MUL = 49;
	localparam int SPB_MUL = 4;
	localparam int MUL_EXTRA_W = 6;

	typedef enum logic [3:0] {
		PH_HUNT   = 4'b0001,
		PH_DATA   = 4'b0010,
		PH_PARITY = 4'b0100,
		PH_STOP   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [DBC_W-1:0] data_bit_count;
		logic parity_enable;
		logic [SBC_W-1:0] stop_bit_count;
	} frame_cfg_t;

	// crossing flag of the newest sample and flag of the sample leaving the window
	typedef struct packed {
		logic flag;
		logic old;
	} ring_beat_t;

endpackage

// ===== src/kcs_if.sv =====
// handshake channels of the fsk decoder
interface kcs_sample_if;
	logic valid;
	logic ready;
	logic signed [kcs_pkg::SAMPLE_W-1:0] audio_sample;
	modport source (output valid, output audio_sample, input ready);
	modport sink (input valid, input audio_sample, output ready);
endinterface

interface kcs_byte_if;
	logic valid;
	logic ready;
	logic [kcs_pkg::BYTE_W-1:0] byte_value;
	modport source (output valid, output byte_value, input ready);
	modport sink (input valid, input byte_value, output ready);
endinterface

interface kcs_cfg_if;
	logic valid;
	logic ready;
	logic [kcs_pkg::CFG_IDX_W-1:0] index;
	logic [kcs_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/kcs_ring.sv =====
// crossing flag ring memory with sign tracking and window tail read
module kcs_ring #(
	parameter int DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic sign,
	input  logic [$clog2(DEPTH+1)-1:0] spb,
	output kcs_pkg::ring_beat_t beat_s1
);

	localparam int PW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH+1);
	localparam int AW = LW + 1;

	logic mem [DEPTH];
	logic prev_sign_q;
	logic [PW-1:0] wp_q;
	logic [PW-1:0] wp_next;
	logic [PW-1:0] raddr;
	logic [AW-1:0] wp_plus;
	logic flag;

	assign flag = sign ^ prev_sign_q;
	assign wp_next = (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign wp_plus = AW'(wp_q) + 1'b1;

	// oldest sample of the window once the newest sits at wp_q
	always_comb begin
		if (wp_plus >= AW'(spb)) begin
			raddr = PW'(wp_plus - AW'(spb));
		end else begin
			raddr = PW'(wp_plus + AW'(DEPTH) - AW'(spb));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sign_q <= 1'b0;
			wp_q <= '0;
		end else if (accept) begin
			prev_sign_q <= sign;
			wp_q <= wp_next;
		end
	end

	// tail entry is never the one written in the same cycle since spb >= 2
	always_ff @(posedge clk) begin
		if (accept) begin
			mem[wp_q] <= flag;
			beat_s1.old <= mem[raddr];
			beat_s1.flag <= flag;
		end
	end

endmodule

// ===== src/kcs_frame.sv =====
// window crossing count, bit decision and frame sequencer with output register
module kcs_frame #(
	parameter int DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic restart,
	input  kcs_pkg::frame_cfg_t cfg,
	input  logic [$clog2(DEPTH+1)-1:0] spb,
	input  logic in_valid,
	output logic in_ready,
	input  kcs_pkg::ring_beat_t beat_s1,
	output logic out_valid,
	input  logic out_ready,
	output logic [kcs_pkg::BYTE_W-1:0] out_byte
);

	localparam int LW = $clog2(DEPTH+1);
	localparam int MW = LW + kcs_pkg::MUL_EXTRA_W;

	logic valid_s1;
	logic [LW-1:0] cnt_q;
	logic [LW-1:0] fill_q;
	kcs_pkg::phase_t phase_q;
	logic [kcs_pkg::BIT_IDX_W-1:0] bit_q;
	logic [kcs_pkg::BYTE_W-1:0] byte_q;
	logic out_valid_q;
	logic [kcs_pkg::BYTE_W-1:0] out_byte_q;

	logic [LW-1:0] cnt_n;
	logic [LW-1:0] fill_n;
	logic full;
	logic one;
	logic [LW-1:0] cnt_d;
	logic [LW-1:0] fill_d;
	kcs_pkg::phase_t phase_d;
	logic [kcs_pkg::BIT_IDX_W-1:0] bit_d;
	logic [kcs_pkg::BYTE_W-1:0] byte_d;
	logic [kcs_pkg::BYTE_W-1:0] emit_byte;
	logic emit;
	logic go_data;
	logic go_parity;
	logic go_stop;
	logic adv;
	logic accept;

	always_comb begin
		cnt_n = cnt_q;
		fill_n = fill_q;
		if (fill_q < spb) begin
			// the pair across the window start is not counted
			if (fill_q != '0) begin
				cnt_n = cnt_q + LW'(beat_s1.flag);
			end
			fill_n = fill_q + 1'b1;
		end else begin
			cnt_n = cnt_q + LW'(beat_s1.flag) - LW'(beat_s1.old);
		end
	end

	assign full = fill_n >= spb;
	assign one = (MW'(cnt_n) * MW'(kcs_pkg::CROSS_MUL)) > (MW'(spb) * MW'(kcs_pkg::SPB_MUL));

	always_comb begin
		cnt_d = cnt_n;
		fill_d = fill_n;
		phase_d = phase_q;
		bit_d = bit_q;
		byte_d = byte_q;
		emit = 1'b0;
		emit_byte = byte_q;
		go_data = 1'b0;
		go_parity = 1'b0;
		go_stop = 1'b0;
		if (full) begin
			case (phase_q)
				kcs_pkg::PH_HUNT: begin
					if (!one) begin
						cnt_d = '0;
						fill_d = '0;
						byte_d = '0;
						go_data = 1'b1;
					end
				end
				kcs_pkg::PH_DATA: begin
					cnt_d = '0;
					fill_d = '0;
					if (bit_q < kcs_pkg::BIT_IDX_W'(kcs_pkg::BYTE_W) && one) begin
						byte_d[bit_q[2:0]] = 1'b1;
					end
					bit_d = bit_q + 1'b1;
					if (bit_d >= cfg.data_bit_count) begin
						go_parity = 1'b1;
					end
				end
				kcs_pkg::PH_PARITY: begin
					cnt_d = '0;
					fill_d = '0;
					go_stop = 1'b1;
				end
				kcs_pkg::PH_STOP: begin
					cnt_d = '0;
					fill_d = '0;
					bit_d = bit_q + 1'b1;
					if (bit_d >= kcs_pkg::BIT_IDX_W'(cfg.stop_bit_count)) begin
						emit = 1'b1;
					end
				end
				default: begin
					phase_d = kcs_pkg::PH_HUNT;
				end
			endcase
		end
		// skip empty frame parts
		if (go_data) begin
			bit_d = '0;
			if (cfg.data_bit_count != '0) begin
				phase_d = kcs_pkg::PH_DATA;
			end else begin
				go_parity = 1'b1;
			end
		end
		if (go_parity) begin
			bit_d = '0;
			if (cfg.parity_enable) begin
				phase_d = kcs_pkg::PH_PARITY;
			end else begin
				go_stop = 1'b1;
			end
		end
		if (go_stop) begin
			bit_d = '0;
			if (cfg.stop_bit_count != '0) begin
				phase_d = kcs_pkg::PH_STOP;
			end else begin
				emit = 1'b1;
			end
		end
		if (emit) begin
			emit_byte = byte_d;
			phase_d = kcs_pkg::PH_HUNT;
			cnt_d = '0;
			fill_d = '0;
			bit_d = '0;
			byte_d = '0;
		end
	end

	// a beat that yields no byte moves on even while the output waits
	assign adv = !emit || !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q <= '0;
			fill_q <= '0;
			phase_q <= kcs_pkg::PH_HUNT;
			bit_q <= '0;
			byte_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (restart) begin
				cnt_q <= '0;
				fill_q <= '0;
				phase_q <= kcs_pkg::PH_HUNT;
				bit_q <= '0;
				byte_q <= '0;
			end else if (valid_s1 && adv) begin
				cnt_q <= cnt_d;
				fill_q <= fill_d;
				phase_q <= phase_d;
				bit_q <= bit_d;
				byte_q <= byte_d;
			end
			if (valid_s1 && adv && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv && emit) begin
			out_byte_q <= emit_byte;
		end
	end

	a_empty_window_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == '0 |-> cnt_q == '0)
		else $error("crossing count set in an empty window");

	a_count_below_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != '0 |-> cnt_q < fill_q)
		else $error("crossing count reached window fill");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= spb)
		else $error("window fill beyond window length");

	a_slide_only_hunting: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != kcs_pkg::PH_HUNT |-> fill_q < spb)
		else $error("full window kept outside hunting");

	a_data_index: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == kcs_pkg::PH_DATA |-> bit_q < cfg.data_bit_count)
		else $error("data bit index past data bit count");

	a_stall_holds_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_byte_q))
		else $error("pending byte lost under stall");

endmodule

// ===== src/kcs_fsk_decoder.sv =====
// top level of the fsk decoder: configuration registers, ring memory and frame sequencer
// throughput: one sample per cycle unless a byte waits on a stalled byte_ch; the ring
// memory has one write and one read port and both are used once per sample, the count
// update closes in the stage after the read, and the output register holds the byte
// reset: arst_n sets the registers to their defaults and clears sign, ring pointer and frame state at once
// the ring memory is not cleared; a window only reads entries written since its start
module kcs_fsk_decoder #(
	parameter int MAX_SAMPLES_PER_BIT = 256
) (
	input logic clk,
	input logic arst_n,
	kcs_sample_if.sink sample_ch,
	kcs_byte_if.source byte_ch,
	kcs_cfg_if.sink cfg_ch
);

	localparam int LW = $clog2(MAX_SAMPLES_PER_BIT+1);
	localparam int CW = (LW > kcs_pkg::SPB_W) ? LW : kcs_pkg::SPB_W;

	logic [kcs_pkg::SPB_W-1:0] spb_q;
	kcs_pkg::frame_cfg_t frame_cfg_q;
	logic [CW-1:0] spb_wide;
	logic [LW-1:0] spb_eff;
	logic cfg_write;
	logic restart;
	logic accept;
	kcs_pkg::ring_beat_t beat_s1;

	assign cfg_ch.ready = 1'b1;
	assign cfg_write = cfg_ch.valid && cfg_ch.ready;
	assign restart = cfg_write && (cfg_ch.index <= kcs_pkg::REG_STOP_BIT_COUNT);
	assign accept = sample_ch.valid && sample_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spb_q <= kcs_pkg::SPB_RESET;
			frame_cfg_q.data_bit_count <= kcs_pkg::DBC_RESET;
			frame_cfg_q.parity_enable <= kcs_pkg::SBC_PAR_RESET;
			frame_cfg_q.stop_bit_count <= kcs_pkg::SBC_RESET;
		end else if (cfg_write) begin
			case (cfg_ch.index)
				kcs_pkg::REG_SAMPLES_PER_BIT: begin
					spb_q <= cfg_ch.data;
				end
				kcs_pkg::REG_DATA_BIT_COUNT: begin
					frame_cfg_q.data_bit_count <= cfg_ch.data[kcs_pkg::DBC_W-1:0];
				end
				kcs_pkg::REG_PARITY_ENABLE: begin
					frame_cfg_q.parity_enable <= cfg_ch.data[0];
				end
				kcs_pkg::REG_STOP_BIT_COUNT: begin
					frame_cfg_q.stop_bit_count <= cfg_ch.data[kcs_pkg::SBC_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// window length clamped to SPB_MIN and to the ring depth
	assign spb_wide = CW'(spb_q);
	always_comb begin
		if (spb_wide < CW'(kcs_pkg::SPB_MIN)) begin
			spb_eff = LW'(kcs_pkg::SPB_MIN);
		end else if (spb_wide > CW'(MAX_SAMPLES_PER_BIT)) begin
			spb_eff = LW'(MAX_SAMPLES_PER_BIT);
		end else begin
			spb_eff = LW'(spb_wide);
		end
	end

	kcs_ring #(
		.DEPTH(MAX_SAMPLES_PER_BIT)
	) u_ring (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.sign(sample_ch.audio_sample[kcs_pkg::SAMPLE_W-1]),
		.spb(spb_eff),
		.beat_s1(beat_s1)
	);

	kcs_frame #(
		.DEPTH(MAX_SAMPLES_PER_BIT)
	) u_frame (
		.clk(clk),
		.arst_n(arst_n),
		.restart(restart),
		.cfg(frame_cfg_q),
		.spb(spb_eff),
		.in_valid(sample_ch.valid),
		.in_ready(sample_ch.ready),
		.beat_s1(beat_s1),
		.out_valid(byte_ch.valid),
		.out_ready(byte_ch.ready),
		.out_byte(byte_ch.byte_value)
	);

endmodule
